// ===== rtl/core/rrbm_pkg.sv =====
`timescale 1ns / 1ps

package rrbm_pkg;

    // Access kinds carried in the input tuser
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_ROM   = 2'd1,
        KIND_RAM   = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Configuration register indexes
    localparam logic CFG_ROM_BANKS = 1'b0;
    localparam logic CFG_RAM_BANKS = 1'b1;

    // Register window selected by address bits 15:13 on a write
    localparam logic [2:0] WIN_RAM_EN   = 3'd0;
    localparam logic [2:0] WIN_BANK_LOW = 3'd1;
    localparam logic [2:0] WIN_BANK_HI  = 3'd2;
    localparam logic [2:0] WIN_MODE     = 3'd3;
    localparam logic [2:0] WIN_EXT_RAM  = 3'd5;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    // Remainder steps: two bits of dividend per step, 8-bit dividend
    localparam int          NUM_STEPS = 4;
    localparam logic [1:0]  LAST_STEP = 2'(NUM_STEPS - 1);

    localparam int OFFSET_W = 21;
    localparam int CFG_W    = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic       start;
        logic       step;
        logic [1:0] step_idx;
        logic       load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

    // One restoring remainder step: shift in one dividend bit, subtract if it fits
    function automatic logic [8:0] mod_step(input logic [8:0] r, input logic b,
                                            input logic [8:0] m);
        logic [9:0] t;
        t = {r, b};
        if (t >= {1'b0, m})
            t = t - {1'b0, m};
        return t[8:0];
    endfunction

endpackage

// ===== rtl/core/rrbm_ctrl.sv =====
`timescale 1ns / 1ps

module rrbm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rrbm_pkg::status_t status,
    output rrbm_pkg::cmd_t   cmd
);
    import rrbm_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = status.out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready     = 1'b0;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.step_idx = step_reg;
        cmd.load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                cmd.load = (step_reg == LAST_STEP) && status.out_free;
            end
            ST_HOLD:
            begin
                cmd.load = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/rrbm_datapath.sv =====
`timescale 1ns / 1ps

module rrbm_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [23:0]                s_tdata,
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [rrbm_pkg::CFG_W-1:0] cfg_data,
    input  rrbm_pkg::cmd_t             cmd,
    output rrbm_pkg::status_t          status
);
    import rrbm_pkg::*;

    // Configuration and mapper state
    logic [8:0] rom_banks_reg;
    logic [2:0] ram_banks_reg;
    logic [4:0] bank_low_reg;
    logic [1:0] bank_high_reg;
    logic       mode_reg;
    logic       ram_on_reg;

    // Item under work
    kind_t      kind_reg;
    logic [15:0] addr_reg;

    // Remainders of switchable and fixed bank numbers
    logic [8:0] rem_sw_reg, rem_sw_next;
    logic [8:0] rem_fx_reg, rem_fx_next;

    // Result register
    logic                out_valid_reg;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                ram_ok_reg, ram_ok_next;
    logic [6:0]          rom_bank_reg, rom_bank_next;
    logic [1:0]          ram_bank_reg, ram_bank_next;

    logic [15:0] in_addr;
    logic [7:0]  in_data;
    logic [8:0]  modulus;
    logic [6:0]  sw_raw;
    logic [7:0]  sw_div;
    logic [7:0]  fx_div;
    logic [2:0]  bit_hi;
    logic [2:0]  bit_lo;
    logic [8:0]  sw_mid;
    logic [8:0]  fx_mid;
    logic [6:0]  fx_bank;
    logic [1:0]  ram_bank;

    assign in_addr = s_tdata[15:0];
    assign in_data = s_tdata[23:16];

    // Control state: configuration, bank registers, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_banks_reg <= 9'd2;
            ram_banks_reg <= 3'd0;
            bank_low_reg  <= 5'd1;
            bank_high_reg <= 2'd0;
            mode_reg      <= 1'b0;
            ram_on_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROM_BANKS: rom_banks_reg <= cfg_data[8:0];
                    CFG_RAM_BANKS: ram_banks_reg <= cfg_data[2:0];
                    default:       rom_banks_reg <= rom_banks_reg;
                endcase
            end
            // Register writes take effect when the beat is taken
            if (cmd.start && (kind_t'(s_tuser) == KIND_WRITE))
            begin
                unique case (in_addr[15:13])
                    WIN_RAM_EN:   ram_on_reg    <= (in_data[3:0] == RAM_EN_KEY);
                    WIN_BANK_LOW: bank_low_reg  <= (in_data[4:0] == 5'd0) ? 5'd1
                                                                           : in_data[4:0];
                    WIN_BANK_HI:  bank_high_reg <= in_data[1:0];
                    WIN_MODE:     mode_reg      <= in_data[0];
                    default:      ram_on_reg    <= ram_on_reg;
                endcase
            end
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg <= kind_t'(s_tuser);
            addr_reg <= in_addr;
        end
        rem_sw_reg <= rem_sw_next;
        rem_fx_reg <= rem_fx_next;
        if (cmd.load)
        begin
            offset_reg   <= offset_next;
            ram_ok_reg   <= ram_ok_next;
            rom_bank_reg <= rom_bank_next;
            ram_bank_reg <= ram_bank_next;
        end
    end

    // Dividends and modulus; a zero ROM bank count acts as two
    always_comb
    begin
        modulus = (rom_banks_reg == 9'd0) ? 9'd2 : rom_banks_reg;
        sw_raw  = {(mode_reg ? 2'b00 : bank_high_reg), bank_low_reg};
        if (bank_low_reg == 5'd0)
            sw_raw = sw_raw + 7'd1;
        sw_div  = {1'b0, sw_raw};
        fx_div  = {1'b0, (mode_reg ? bank_high_reg : 2'b00), 5'd0};
    end

    // Two remainder steps per cycle, most significant bits first
    always_comb
    begin
        bit_hi      = {~cmd.step_idx, 1'b1};
        bit_lo      = {~cmd.step_idx, 1'b0};
        sw_mid      = mod_step(rem_sw_reg, sw_div[bit_hi], modulus);
        fx_mid      = mod_step(rem_fx_reg, fx_div[bit_hi], modulus);
        rem_sw_next = rem_sw_reg;
        rem_fx_next = rem_fx_reg;
        if (cmd.start)
        begin
            rem_sw_next = '0;
            rem_fx_next = '0;
        end
        else if (cmd.step)
        begin
            rem_sw_next = mod_step(sw_mid, sw_div[bit_lo], modulus);
            rem_fx_next = mod_step(fx_mid, fx_div[bit_lo], modulus);
        end
    end

    // RAM bank: bank_high below four, one conditional subtract suffices
    always_comb
    begin
        ram_bank = bank_high_reg;
        if (!mode_reg || (ram_banks_reg == 3'd1))
            ram_bank = 2'd0;
        else if ((ram_banks_reg != 3'd0) && ({1'b0, bank_high_reg} >= ram_banks_reg))
            ram_bank = 2'(bank_high_reg - ram_banks_reg[1:0]);
    end

    // Result assembly; the last remainder step feeds the result directly
    always_comb
    begin
        fx_bank       = rem_fx_next[6:0];
        rom_bank_next = (rem_sw_next[6:0] == 7'd0) ? 7'd1 : rem_sw_next[6:0];
        ram_bank_next = ram_bank;
        offset_next   = '0;
        ram_ok_next   = 1'b0;
        unique case (kind_reg)
            KIND_ROM:
            begin
                if (!addr_reg[15])
                begin
                    if (!addr_reg[14])
                        offset_next = {fx_bank, addr_reg[13:0]};
                    else
                        offset_next = {rom_bank_next, addr_reg[13:0]};
                end
            end
            KIND_RAM:
            begin
                if (ram_on_reg && (addr_reg[15:13] == WIN_EXT_RAM))
                begin
                    ram_ok_next = 1'b1;
                    offset_next = {6'd0, ram_bank, addr_reg[12:0]};
                end
            end
            default:
            begin
                offset_next = '0;
            end
        endcase
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {1'b0, ram_bank_reg, rom_bank_reg, ram_ok_reg, offset_reg};

endmodule

// ===== rtl/core/rom_ram_bank_mapper.sv =====
`timescale 1ns / 1ps

// Cartridge ROM/RAM bank controller.
// Input stream: one beat per bus access. s_tuser holds the access kind
// (register write, ROM translate, RAM translate); s_tdata holds address and
// data. Each beat yields exactly one output beat with the flat offset, the
// RAM hit flag and the current ROM and RAM banks after the access.
// Configuration: cfg_we/cfg_index/cfg_data set the ROM and RAM bank counts;
// write them only while no beat is in flight.
// The bank numbers are reduced modulo the ROM bank count by a remainder unit
// that handles two dividend bits per cycle; the result is then loaded into
// the output register, and a new beat is taken only after that.
// The output sits in a register, so a stalled receiver holds only the
// finished result; the block takes no beat while one is in flight, and a
// second finished result waits in the hold state for m_tready.
// Reset (rst_n low, asynchronous) restores 2 ROM banks, no RAM banks,
// bank_low 1, bank_high 0, mode 0, RAM disabled, and drops any pending beat.
module rom_ram_bank_mapper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // offset[20:0], ram_ok[21], cur_rom_bank[28:22],
                                   // cur_ram_bank[30:29], zero[31]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    import rrbm_pkg::*;

    cmd_t    cmd;
    status_t status;

    rrbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rrbm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef SYNTHESIS
    // A taken beat starts the remainder unit at its first step
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (cmd.step && (cmd.step_idx == 2'd0)))
        else $error("remainder unit did not start after input beat");

    // A result is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    // One access in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken while busy");

    // Switchable ROM bank is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[28:22] != 7'd0))
        else $error("switchable ROM bank reported as zero");
`endif

endmodule
